// ===== rtl/ltfs_pkg.sv =====
// ----------------------------------------------------------------------------
// ltfs_pkg
// Types, register codes and reset constants of the LED twinkle fade sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ltfs_pkg;

	localparam int PAL_REGS = 5;

	localparam logic [2:0]  PALETTE_SIZE_RST = 3'd2;
	localparam logic [31:0] PALETTE_0_RST    = 32'hF0FF0000;
	localparam logic [31:0] PALETTE_1_RST    = 32'hDC008000;
	localparam logic [31:0] PALETTE_N_RST    = 32'h00000000;
	localparam logic [7:0]  WAIT_SCALE_RST   = 8'd60;

	typedef enum logic [2:0] {
		CFG_PALETTE_SIZE = 3'd0,
		CFG_ENTRY_0      = 3'd1,
		CFG_ENTRY_1      = 3'd2,
		CFG_ENTRY_2      = 3'd3,
		CFG_ENTRY_3      = 3'd4,
		CFG_ENTRY_4      = 3'd5,
		CFG_WAIT_SCALE   = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_INIT    = 3'd0,
		PH_IDLE    = 3'd1,
		PH_FADEIN  = 3'd2,
		PH_HOLD    = 3'd3,
		PH_FADEOUT = 3'd4
	} phase_t;

	typedef struct packed {
		logic [2:0]  led_index;
		logic [31:0] now_ms;
		logic [5:0]  rand_wait;
		logic [2:0]  rand_pick;
		logic [9:0]  rand_hold;
	} ltfs_in_t;

	typedef struct packed {
		logic [2:0] out_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} ltfs_out_t;

	typedef struct packed {
		phase_t      led_phase;
		logic [13:0] wait_left;
		logic [7:0]  fade_level;
		logic [7:0]  peak_level;
		logic [23:0] chosen_colour;
		logic [31:0] hold_start;
		logic [9:0]  hold_length;
		logic        hold_armed;
		logic [23:0] shown_colour;
	} led_state_t;

	function automatic logic [23:0] scale_rgb(input logic [23:0] rgb, input logic [7:0] s);
		logic [23:0] res;
		logic [16:0] prod;
		res = '0;
		for (int ch = 0; ch < 3; ch++) begin
			prod = 17'(rgb[ch*8 +: 8]) * (17'(s) + 17'd1);
			res[ch*8 +: 8] = prod[15:8];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/led_twinkle_fade_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// led_twinkle_fade_sequencer_core
// Per-LED twinkle sequencer: init, idle wait, fade-in, hold, fade-out.
// Accepted requests pass through the input stage and then the result register.
// Throughput: one request per cycle unless the result register stalls; LED state is
// read on accept and written back from the input stage, forwarded to a same-LED read.
// Reset: configuration returns to defaults, pipeline empties, per-LED valid bits clear
// so every LED reads as black in its init phase.
// ----------------------------------------------------------------------------
`default_nettype none

module led_twinkle_fade_sequencer_core #(
	parameter int LED_COUNT     = 8,
	parameter int PALETTE_DEPTH = 5
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  ltfs_pkg::ltfs_in_t      in_req,
	output logic                    res_valid,
	input  wire                     res_ready,
	output ltfs_pkg::ltfs_out_t     res,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [2:0]              cfg_index,
	input  wire  [31:0]             cfg_data
);

	localparam int AW      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int PAL_LIM = (PALETTE_DEPTH < ltfs_pkg::PAL_REGS) ?
		PALETTE_DEPTH : ltfs_pkg::PAL_REGS;

	logic [2:0]  palette_size_q;
	logic [31:0] palette_q [ltfs_pkg::PAL_REGS];
	logic [7:0]  wait_scale_q;

	ltfs_pkg::led_state_t state_mem [LED_COUNT];
	logic [LED_COUNT-1:0] state_vld_q;

	ltfs_pkg::ltfs_in_t   in_s1;
	logic                 valid_s1_q;
	ltfs_pkg::led_state_t rd_state_s1;
	logic                 rd_vld_s1;

	ltfs_pkg::ltfs_out_t res_q;
	logic                res_valid_q;

	logic                 adv_s1;
	logic                 in_fire;
	logic                 in_range_s1;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;
	ltfs_pkg::led_state_t cur;
	ltfs_pkg::led_state_t nxt;
	logic [2:0]           sz_eff;
	logic [2:0]           pick;
	logic [31:0]          entry;
	logic [7:0]           fade_inc;
	logic [9:0]           hold_len;
	logic [31:0]          elapsed;
	logic [13:0]          wait_prod;

	assign adv_s1    = valid_s1_q && (!res_valid_q || res_ready);
	assign in_ready  = !valid_s1_q || adv_s1;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign in_range_s1 = 32'(in_s1.led_index) < LED_COUNT;
	assign wr_en       = adv_s1 && in_range_s1;
	assign wr_addr     = AW'(in_s1.led_index);
	assign rd_addr     = AW'(in_req.led_index);

	always_comb begin
		cur = rd_vld_s1 ? rd_state_s1 : '0;
		nxt = cur;
		sz_eff = (palette_size_q == 3'd0) ? 3'd1 : palette_size_q;
		if (32'(sz_eff) > PAL_LIM) begin
			sz_eff = 3'(PAL_LIM);
		end
		pick = (in_s1.rand_pick > (sz_eff - 3'd1)) ? (sz_eff - 3'd1) : in_s1.rand_pick;
		entry = palette_q[pick];
		fade_inc = cur.fade_level + 8'd1;
		hold_len = cur.hold_armed ? cur.hold_length : in_s1.rand_hold;
		elapsed = in_s1.now_ms - cur.hold_start;
		wait_prod = 14'(in_s1.rand_wait) * 14'(wait_scale_q);
		case (cur.led_phase)
			ltfs_pkg::PH_IDLE: begin
				if (cur.wait_left != 14'd0) begin
					nxt.wait_left = cur.wait_left - 14'd1;
				end else begin
					nxt.chosen_colour = entry[23:0];
					nxt.peak_level    = entry[31:24];
					nxt.fade_level    = 8'd0;
					nxt.led_phase     = ltfs_pkg::PH_FADEIN;
				end
			end
			ltfs_pkg::PH_FADEIN: begin
				nxt.shown_colour = ltfs_pkg::scale_rgb(cur.chosen_colour, cur.fade_level);
				nxt.fade_level   = fade_inc;
				if (fade_inc >= cur.peak_level) begin
					nxt.led_phase  = ltfs_pkg::PH_HOLD;
					nxt.hold_start = in_s1.now_ms;
					nxt.hold_armed = 1'b0;
				end
			end
			ltfs_pkg::PH_HOLD: begin
				nxt.hold_length = hold_len;
				nxt.hold_armed  = 1'b1;
				if (elapsed >= 32'(hold_len)) begin
					nxt.fade_level = cur.peak_level;
					nxt.led_phase  = ltfs_pkg::PH_FADEOUT;
					nxt.hold_armed = 1'b0;
				end
			end
			ltfs_pkg::PH_FADEOUT: begin
				nxt.shown_colour = ltfs_pkg::scale_rgb(cur.chosen_colour, cur.fade_level);
				if (cur.fade_level != 8'd0) begin
					nxt.fade_level = cur.fade_level - 8'd1;
				end else begin
					nxt.led_phase = ltfs_pkg::PH_INIT;
				end
			end
			default: begin
				nxt.wait_left  = wait_prod;
				nxt.led_phase  = ltfs_pkg::PH_IDLE;
				nxt.hold_armed = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= ltfs_pkg::PALETTE_SIZE_RST;
			palette_q[0]   <= ltfs_pkg::PALETTE_0_RST;
			palette_q[1]   <= ltfs_pkg::PALETTE_1_RST;
			palette_q[2]   <= ltfs_pkg::PALETTE_N_RST;
			palette_q[3]   <= ltfs_pkg::PALETTE_N_RST;
			palette_q[4]   <= ltfs_pkg::PALETTE_N_RST;
			wait_scale_q   <= ltfs_pkg::WAIT_SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ltfs_pkg::CFG_PALETTE_SIZE: palette_size_q <= cfg_data[2:0];
				ltfs_pkg::CFG_ENTRY_0:      palette_q[0]   <= cfg_data;
				ltfs_pkg::CFG_ENTRY_1:      palette_q[1]   <= cfg_data;
				ltfs_pkg::CFG_ENTRY_2:      palette_q[2]   <= cfg_data;
				ltfs_pkg::CFG_ENTRY_3:      palette_q[3]   <= cfg_data;
				ltfs_pkg::CFG_ENTRY_4:      palette_q[4]   <= cfg_data;
				ltfs_pkg::CFG_WAIT_SCALE:   wait_scale_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			state_mem[wr_addr] <= nxt;
		end
		if (in_fire) begin
			in_s1       <= in_req;
			rd_state_s1 <= (wr_en && wr_addr == rd_addr) ? nxt : state_mem[rd_addr];
		end
		if (adv_s1) begin
			res_q.out_index <= in_s1.led_index;
			res_q.red       <= in_range_s1 ? nxt.shown_colour[23:16] : 8'd0;
			res_q.green     <= in_range_s1 ? nxt.shown_colour[15:8]  : 8'd0;
			res_q.blue      <= in_range_s1 ? nxt.shown_colour[7:0]   : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_vld_q <= '0;
			rd_vld_s1   <= 1'b0;
			valid_s1_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				state_vld_q[wr_addr] <= 1'b1;
			end
			if (in_fire) begin
				rd_vld_s1 <= (wr_en && wr_addr == rd_addr) || state_vld_q[rd_addr];
			end
			if (in_ready) begin
				valid_s1_q <= in_valid;
			end
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ltfs_checker.sv =====
// ----------------------------------------------------------------------------
// ltfs_checker
// Port-level checks of the LED twinkle fade sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ltfs_checker #(
	parameter int LED_COUNT = 8
) (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_ready,
	input wire                 res_valid,
	input wire                 res_ready,
	input ltfs_pkg::ltfs_out_t res,
	input wire                 cfg_valid,
	input wire                 cfg_ready
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> in_ready)
		else $error("request refused with empty result register");

	a_out_of_range_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (32'(res.out_index) >= LED_COUNT) |->
			res.red == 8'd0 && res.green == 8'd0 && res.blue == 8'd0)
		else $error("LED outside range shows colour");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind led_twinkle_fade_sequencer_core ltfs_checker #(.LED_COUNT(LED_COUNT)) u_ltfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for led_twinkle_fade_sequencer_core. Frame requests for
// the eight LEDs run through several palette and wait settings with random idle
// gaps on both ports. A per-LED predictor works out the shown colour of every
// accepted request, and each result is compared in order against it.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LED_COUNT = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [2:0] CFG_NONE = 3'd7;

	class twinkle_scoreboard;
		logic [2:0]           palette_size;
		logic [31:0]          palette [ltfs_pkg::PAL_REGS];
		logic [7:0]           wait_scale;
		ltfs_pkg::led_state_t led [LED_COUNT];
		ltfs_pkg::ltfs_out_t  expected_colours [$];
		int                   errors;

		function new();
			palette_size = ltfs_pkg::PALETTE_SIZE_RST;
			palette[0] = ltfs_pkg::PALETTE_0_RST;
			palette[1] = ltfs_pkg::PALETTE_1_RST;
			for (int i = 2; i < ltfs_pkg::PAL_REGS; i++)
				palette[i] = ltfs_pkg::PALETTE_N_RST;
			wait_scale = ltfs_pkg::WAIT_SCALE_RST;
			foreach (led[i])
				led[i] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
			ltfs_pkg::CFG_PALETTE_SIZE: palette_size = data[2:0];
			ltfs_pkg::CFG_ENTRY_0, ltfs_pkg::CFG_ENTRY_1, ltfs_pkg::CFG_ENTRY_2,
			ltfs_pkg::CFG_ENTRY_3, ltfs_pkg::CFG_ENTRY_4:
				palette[idx - ltfs_pkg::CFG_ENTRY_0] = data;
			ltfs_pkg::CFG_WAIT_SCALE: wait_scale = data[7:0];
			default: ;
			endcase
		endfunction

		function logic [23:0] dim(logic [23:0] rgb, logic [7:0] level);
			int unsigned v;
			logic [23:0] dimmed;
			for (int k = 0; k < 3; k++) begin
				v = rgb[8*k +: 8] * (level + 1);
				dimmed[8*k +: 8] = 8'(v >> 8);
			end
			return dimmed;
		endfunction

		function void add_frame(ltfs_pkg::ltfs_in_t req);
			ltfs_pkg::led_state_t s;
			logic [2:0] size_eff;
			logic [2:0] top;
			logic [2:0] pick;
			logic [31:0] entry;
			int unsigned wait_frames;
			ltfs_pkg::ltfs_out_t frame;
			s = led[req.led_index];
			case (s.led_phase)
			ltfs_pkg::PH_IDLE: begin
				if (s.wait_left != 0) begin
					s.wait_left = s.wait_left - 14'd1;
				end else begin
					size_eff = palette_size;
					if (size_eff == 3'd0)
						size_eff = 3'd1;
					if (size_eff > 3'(ltfs_pkg::PAL_REGS))
						size_eff = 3'(ltfs_pkg::PAL_REGS);
					top = size_eff - 3'd1;
					pick = (req.rand_pick > top) ? top : req.rand_pick;
					entry = palette[pick];
					s.chosen_colour = entry[23:0];
					s.peak_level = entry[31:24];
					s.fade_level = 8'd0;
					s.led_phase = ltfs_pkg::PH_FADEIN;
				end
			end
			ltfs_pkg::PH_FADEIN: begin
				s.shown_colour = dim(s.chosen_colour, s.fade_level);
				s.fade_level = s.fade_level + 8'd1;
				if (s.fade_level >= s.peak_level) begin
					s.led_phase = ltfs_pkg::PH_HOLD;
					s.hold_start = req.now_ms;
					s.hold_armed = 1'b0;
				end
			end
			ltfs_pkg::PH_HOLD: begin
				if (!s.hold_armed) begin
					s.hold_length = req.rand_hold;
					s.hold_armed = 1'b1;
				end
				if (32'(req.now_ms - s.hold_start) >= {22'd0, s.hold_length}) begin
					s.fade_level = s.peak_level;
					s.led_phase = ltfs_pkg::PH_FADEOUT;
					s.hold_armed = 1'b0;
				end
			end
			ltfs_pkg::PH_FADEOUT: begin
				s.shown_colour = dim(s.chosen_colour, s.fade_level);
				if (s.fade_level != 8'd0)
					s.fade_level = s.fade_level - 8'd1;
				else
					s.led_phase = ltfs_pkg::PH_INIT;
			end
			default: begin
				wait_frames = req.rand_wait * wait_scale;
				s.wait_left = 14'(wait_frames);
				s.led_phase = ltfs_pkg::PH_IDLE;
				s.hold_armed = 1'b0;
			end
			endcase
			led[req.led_index] = s;
			frame.out_index = req.led_index;
			{frame.red, frame.green, frame.blue} = s.shown_colour;
			expected_colours.push_back(frame);
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_colour(ltfs_pkg::ltfs_out_t got);
			ltfs_pkg::ltfs_out_t want;
			if (expected_colours.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending, got %p", $time, got);
				return;
			end
			want = expected_colours.pop_front();
			check_field("out_index", 8'(want.out_index), 8'(got.out_index));
			check_field("red", want.red, got.red);
			check_field("green", want.green, got.green);
			check_field("blue", want.blue, got.blue);
		endfunction

		function int pending();
			return expected_colours.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	ltfs_pkg::ltfs_in_t  in_req;
	logic                res_valid;
	logic                res_ready;
	ltfs_pkg::ltfs_out_t res;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [2:0]          cfg_index;
	logic [31:0]         cfg_data;

	twinkle_scoreboard frames;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          rx_stall_cycles;
	logic [31:0] clock_ms;
	int unsigned cycles = 0;

	led_twinkle_fade_sequencer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("led_twinkle_fade_sequencer_core test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			frames.check_colour(res);
	end

	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_stall_cycles > 0) begin
				res_ready <= 1'b0;
				rx_stall_cycles--;
			end else begin
				res_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic ltfs_pkg::ltfs_in_t frame_req(logic [2:0] idx, logic [31:0] now,
			logic [5:0] rw, logic [2:0] pick, logic [9:0] hold);
		ltfs_pkg::ltfs_in_t req;
		req.led_index = idx;
		req.now_ms = now;
		req.rand_wait = rw;
		req.rand_pick = pick;
		req.rand_hold = hold;
		return req;
	endfunction

	task automatic send_frame(ltfs_pkg::ltfs_in_t req);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= req;
		do @(posedge clk); while (!in_ready);
		frames.add_frame(req);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		frames.write_reg(idx, data);
		@(negedge clk);
	endtask

	// drop valid and hold until every pending result is back
	task automatic settle();
		in_valid <= 1'b0;
		while (frames.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_frames(int count, int focus_pct, int short_wait_pct);
		ltfs_pkg::ltfs_in_t req;
		for (int n = 0; n < count; n++) begin
			clock_ms += $urandom_range(0, 25);
			req.led_index = ($urandom_range(99) < focus_pct) ? 3'd0
				: 3'($urandom_range(0, LED_COUNT - 1));
			req.now_ms = ($urandom_range(99) < 4) ? $urandom : clock_ms;
			req.rand_wait = ($urandom_range(99) < short_wait_pct) ? 6'($urandom_range(0, 2))
				: 6'($urandom_range(0, 63));
			req.rand_pick = 3'($urandom_range(0, 7));
			req.rand_hold = ($urandom_range(99) < 85) ? 10'($urandom_range(200, 599))
				: 10'($urandom_range(0, 1023));
			send_frame(req);
		end
	endtask

	initial begin
		frames = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle_pct = 12;
		rx_idle_pct = 65;
		rx_stall_cycles = 0;
		clock_ms = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < LED_COUNT; i++)
			send_frame(frame_req(3'(i), 32'd0, (i == 1) ? 6'h3F : 6'h00, 3'd0, 10'd0));
		send_frame(frame_req(3'd0, 32'hFFFF_FFFF, 6'h3F, 3'h7, 10'h3FF));
		send_frame(frame_req(3'd2, 32'h0000_0000, 6'h2A, 3'd0, 10'h155));
		for (int i = 0; i < 3; i++)
			send_frame(frame_req(3'd0, 32'h5555_5555 << i, 6'h15, 3'h2, 10'h2AA));

		// size zero, blank peak, zero wait scale
		settle();
		write_cfg(ltfs_pkg::CFG_PALETTE_SIZE, 32'd0);
		write_cfg(ltfs_pkg::CFG_ENTRY_0, 32'h00FF_FFFF);
		write_cfg(ltfs_pkg::CFG_WAIT_SCALE, 32'd0);
		write_cfg(CFG_NONE, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		for (int i = 0; i < 5; i++)
			send_frame(frame_req(3'd3, 32'(100 + i), 6'h3F, 3'h5, 10'd0));

		settle();
		write_cfg(ltfs_pkg::CFG_PALETTE_SIZE, 32'd5);
		for (int i = 0; i < ltfs_pkg::PAL_REGS; i++)
			write_cfg(3'(ltfs_pkg::CFG_ENTRY_0 + i),
				(i == 2) ? 32'd0 : {8'($urandom_range(0, 12)), 24'($urandom)});
		write_cfg(ltfs_pkg::CFG_WAIT_SCALE, 32'd1);
		cfg_valid <= 1'b0;
		run_frames(350, 0, 80);

		settle();
		tx_idle_pct = 65;
		rx_idle_pct = 12;
		write_cfg(ltfs_pkg::CFG_PALETTE_SIZE, 32'd7);
		for (int i = 0; i < 4; i++)
			write_cfg(3'(ltfs_pkg::CFG_ENTRY_0 + i),
				{8'($urandom_range(0, 40)), 24'($urandom)});
		write_cfg(ltfs_pkg::CFG_ENTRY_4, 32'hFFFF_FFFF);
		write_cfg(ltfs_pkg::CFG_WAIT_SCALE, 32'd0);
		cfg_valid <= 1'b0;
		clock_ms = 32'hFFFF_F800;
		run_frames(450, 85, 80);

		settle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_cfg(ltfs_pkg::CFG_PALETTE_SIZE, 32'd3);
		for (int i = 0; i < 3; i++)
			write_cfg(3'(ltfs_pkg::CFG_ENTRY_0 + i),
				{8'($urandom_range(0, 6)), 24'($urandom)});
		write_cfg(ltfs_pkg::CFG_WAIT_SCALE, 32'd2);
		cfg_valid <= 1'b0;
		rx_stall_cycles = 300;
		run_frames(150, 0, 80);
		settle();
		run_frames(150, 0, 80);

		settle();
		write_cfg(ltfs_pkg::CFG_PALETTE_SIZE, 32'd1);
		write_cfg(ltfs_pkg::CFG_WAIT_SCALE, 32'd255);
		cfg_valid <= 1'b0;
		run_frames(200, 0, 97);

		settle();
		if (frames.errors == 0 && frames.pending() == 0)
			$display("led_twinkle_fade_sequencer_core test passed");
		else
			$display("led_twinkle_fade_sequencer_core test failed");
		$finish;
	end
endmodule
